// ===== src/r2y_pkg.sv =====
`timescale 1ns / 1ps
package r2y_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int FW_W      = 13;
	localparam int WEIGHT_W  = 32;
	localparam int IDX_W     = 2;

	typedef enum logic [IDX_W-1:0] {
		REG_LUMA_WEIGHTS  = 2'd0,
		REG_BLUE_DIFF     = 2'd1,
		REG_RED_DIFF      = 2'd2,
		REG_FRAME_WIDTH   = 2'd3
	} reg_index_t;

	localparam logic [WEIGHT_W-1:0] LUMA_WEIGHTS_RESET = 32'h000D_4121;
	localparam logic [WEIGHT_W-1:0] BLUE_DIFF_RESET    = 32'h0070_B6DA;
	localparam logic [WEIGHT_W-1:0] RED_DIFF_RESET     = 32'h00EE_A270;
	localparam logic [FW_W-1:0]     FRAME_WIDTH_RESET  = 13'd640;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

endpackage

// ===== src/r2y_weigh.sv =====
`timescale 1ns / 1ps
module r2y_weigh (
	input  r2y_pkg::pixel_t              pixel,
	input  logic [r2y_pkg::WEIGHT_W-1:0] weights,
	output logic signed [15:0]           sum
);
	import r2y_pkg::*;

	logic signed [16:0] prod_r, prod_g, prod_b, prod_a;
	logic signed [17:0] pair_rg, pair_ba;
	logic signed [15:0] sat_rg, sat_ba;

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		if (v > 18'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			return 16'sh8000;
		end else begin
			return v[15:0];
		end
	endfunction

	// Pixel bytes are unsigned, so each gets a zero sign bit before the signed multiply.
	assign prod_r = 17'($signed({1'b0, pixel.red}))   * 17'($signed(weights[7:0]));
	assign prod_g = 17'($signed({1'b0, pixel.green})) * 17'($signed(weights[15:8]));
	assign prod_b = 17'($signed({1'b0, pixel.blue}))  * 17'($signed(weights[23:16]));
	assign prod_a = 17'($signed({1'b0, pixel.alpha})) * 17'($signed(weights[31:24]));

	assign pair_rg = {prod_r[16], prod_r} + {prod_g[16], prod_g};
	assign pair_ba = {prod_b[16], prod_b} + {prod_a[16], prod_a};

	assign sat_rg = sat16(pair_rg);
	assign sat_ba = sat16(pair_ba);

	// The final add wraps at 16 bits.
	assign sum = sat_rg + sat_ba;

endmodule

// ===== src/rgba_to_yuv420_converter.sv =====
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// pixel     pix_valid / pix_ready   red, green, blue, alpha, start_of_frame
// result    res_valid / res_ready   luma, chroma_u, chroma_v, chroma_valid
// config    cfg_we                  cfg_index, cfg_data
//
// One pixel is taken every clock while the result is not stalled.
// Stage one registers the pixel and its chroma flag, stage two holds the finished samples.
// All three weighted sums are computed in parallel between the two stages.
// When the result is stalled, a further pixel waits in stage one, then pix_ready drops.
// arst_n clears the pipeline, the position counters and the registers to their defaults.
module rgba_to_yuv420_converter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [r2y_pkg::IDX_W-1:0]    cfg_index,
	input  logic [r2y_pkg::WEIGHT_W-1:0] cfg_data,
	input  logic                         pix_valid,
	output logic                         pix_ready,
	input  logic [7:0]                   red,
	input  logic [7:0]                   green,
	input  logic [7:0]                   blue,
	input  logic [7:0]                   alpha,
	input  logic                         start_of_frame,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [7:0]                   luma,
	output logic [7:0]                   chroma_u,
	output logic [7:0]                   chroma_v,
	output logic                         chroma_valid
);
	import r2y_pkg::*;

	logic [WEIGHT_W-1:0] luma_w_q, blue_w_q, red_w_q;
	logic [FW_W-1:0]     frame_width_q;
	logic [COL_W-1:0]    column_q;
	logic                odd_row_q;

	logic [FW_W-1:0]     width_eff;
	logic [COL_W-1:0]    column_cur;
	logic                odd_cur;
	logic [FW_W-1:0]     column_inc;
	logic                accept, advance;

	logic                valid_s1, chroma_s1;
	pixel_t              pixel_s1;

	logic signed [15:0]  y_sum, u_sum, v_sum;
	logic signed [9:0]   y_off;
	logic [7:0]          y_val;

	logic                valid_s2, chroma_s2;
	logic [7:0]          luma_s2, u_s2, v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_w_q      <= LUMA_WEIGHTS_RESET;
			blue_w_q      <= BLUE_DIFF_RESET;
			red_w_q       <= RED_DIFF_RESET;
			frame_width_q <= FRAME_WIDTH_RESET;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_LUMA_WEIGHTS: luma_w_q      <= cfg_data;
				REG_BLUE_DIFF:    blue_w_q      <= cfg_data;
				REG_RED_DIFF:     red_w_q       <= cfg_data;
				REG_FRAME_WIDTH:  frame_width_q <= cfg_data[FW_W-1:0];
				default: ;
			endcase
		end
	end

	// A width of zero counts as one; anything above the maximum is capped.
	always_comb begin
		if (frame_width_q == '0) begin
			width_eff = FW_W'(1);
		end else if (frame_width_q > FW_W'(MAX_WIDTH)) begin
			width_eff = FW_W'(MAX_WIDTH);
		end else begin
			width_eff = frame_width_q;
		end
	end

	assign column_cur = start_of_frame ? '0 : column_q;
	assign odd_cur    = start_of_frame ? 1'b0 : odd_row_q;
	assign column_inc = FW_W'(column_cur) + FW_W'(1);

	assign advance   = !valid_s2 || res_ready;
	assign pix_ready = !valid_s1 || advance;
	assign accept    = pix_valid && pix_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q  <= '0;
			odd_row_q <= 1'b0;
		end else if (accept) begin
			if (column_inc >= width_eff) begin
				column_q  <= '0;
				odd_row_q <= !odd_cur;
			end else begin
				column_q  <= column_inc[COL_W-1:0];
				odd_row_q <= odd_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1  <= '{red: red, green: green, blue: blue, alpha: alpha};
			chroma_s1 <= !odd_cur && !column_cur[0];
		end
	end

	r2y_weigh u_weigh_y (.pixel(pixel_s1), .weights(luma_w_q), .sum(y_sum));
	r2y_weigh u_weigh_u (.pixel(pixel_s1), .weights(blue_w_q), .sum(u_sum));
	r2y_weigh u_weigh_v (.pixel(pixel_s1), .weights(red_w_q),  .sum(v_sum));

	assign y_off = $signed({y_sum[15], y_sum[15:7]}) + 10'sd16;

	always_comb begin
		if (y_off < 10'sd0) begin
			y_val = 8'd0;
		end else if (y_off > 10'sd255) begin
			y_val = 8'd255;
		end else begin
			y_val = y_off[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// Chroma is the top byte of the sum plus 128, which always lands in 0..255,
	// so flipping the sign bit is the whole offset-and-clamp.
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			luma_s2   <= y_val;
			chroma_s2 <= chroma_s1;
			u_s2      <= chroma_s1 ? {~u_sum[15], u_sum[14:8]} : 8'd0;
			v_s2      <= chroma_s1 ? {~v_sum[15], v_sum[14:8]} : 8'd0;
		end
	end

	assign res_valid    = valid_s2;
	assign luma         = luma_s2;
	assign chroma_u     = u_s2;
	assign chroma_v     = v_s2;
	assign chroma_valid = chroma_s2;

endmodule

// ===== src/r2y_checker.sv =====
`timescale 1ns / 1ps
module r2y_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pix_valid,
	input logic       pix_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] luma,
	input logic [7:0] chroma_u,
	input logic [7:0] chroma_v,
	input logic       chroma_valid
);

	// A stalled result keeps its samples.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(luma) && $stable(chroma_u)
			&& $stable(chroma_v) && $stable(chroma_valid))
		else $error("result changed while stalled");

	// Pixels without chroma carry zero in both chroma samples.
	a_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !chroma_valid |-> chroma_u == 8'd0 && chroma_v == 8'd0)
		else $error("chroma not zero on a luma-only result");

	// With the result stage empty the block must take a pixel.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> pix_ready)
		else $error("pixel refused while result stage empty");

	// A result that appears after a gap comes from a request accepted and carried through stage one into stage two.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(pix_valid && pix_ready, 2))
		else $error("result without a matching request");

endmodule

bind rgba_to_yuv420_converter r2y_checker u_r2y_checker (.*);
